@@ design/qadd_pkg.sv @@
// ---------------------------------------------------------------------------
// qadd_pkg: shared types and constants
// Field types, configuration register indexes and reset values for the
// quantized int8 add block.
// ---------------------------------------------------------------------------
package qadd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [7:0]  q8_t;
  typedef logic [30:0]        mult_t;
  typedef logic signed [5:0]  shift_t;
  typedef logic [4:0]         post_t;
  typedef logic signed [31:0] word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT_A   = 3'd0,
    REG_SHIFT_A  = 3'd1,
    REG_MULT_B   = 3'd2,
    REG_SHIFT_B  = 3'd3,
    REG_ZERO_A   = 3'd4,
    REG_ZERO_B   = 3'd5,
    REG_ZERO_OUT = 3'd6
  } reg_idx_t;

  localparam mult_t  MULT_RST  = 31'h4000_0000;
  localparam shift_t SHIFT_RST = 6'sd1;
  localparam q8_t    ZERO_RST  = 8'sd0;

  typedef struct packed {
    mult_t  mult_a;
    shift_t shift_a;
    mult_t  mult_b;
    shift_t shift_b;
    q8_t    zero_a;
    q8_t    zero_b;
    q8_t    zero_out;
  } cfg_t;

endpackage

@@ design/qadd_if.sv @@
// ---------------------------------------------------------------------------
// qadd_if: channel interfaces
// Input element pair, result and configuration write channels, each with
// valid/ready handshake.
// ---------------------------------------------------------------------------
interface qadd_in_if import qadd_pkg::*;
  ;
  logic valid;
  logic ready;
  q8_t  elem_a;
  q8_t  elem_b;
  logic last_in;

  modport source (output valid, elem_a, elem_b, last_in, input ready);
  modport sink   (input valid, elem_a, elem_b, last_in, output ready);
endinterface

interface qadd_out_if import qadd_pkg::*;
  ;
  logic valid;
  logic ready;
  q8_t  sum_q;
  logic last_out;

  modport source (output valid, sum_q, last_out, input ready);
  modport sink   (input valid, sum_q, last_out, output ready);
endinterface

interface qadd_cfg_if import qadd_pkg::*;
  ;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/quantized_int8_add_top.sv @@
// Throughput: one element pair per cycle; the four-stage pipeline
// (pre-shift, multiply, round, sum/saturate) advances as a whole and holds
// while a result waits at the output.
// Reset: synchronous, clears stage valid bits and loads register defaults.
// ---------------------------------------------------------------------------
// quantized_int8_add_top: quantized int8 element-wise add
// Rescales two int8 operands, sums them and requantizes to int8.
// ---------------------------------------------------------------------------
module quantized_int8_add_top import qadd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qadd_in_if.sink     in_ch,
  qadd_out_if.source  out_ch,
  qadd_cfg_if.sink    cfg_ch
);

  localparam int STAGES = 4;

  cfg_t              cfg;
  logic              en;
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] lst;
  word_t             ta;
  word_t             tb;

  assign en          = !vld[STAGES-1] || out_ch.ready;
  // an item offered during reset would be dropped, so take none
  assign in_ch.ready = en && !rst;

  qadd_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  qadd_rescale u_rescale_a (
    .clk   (clk),
    .en    (en),
    .elem  (in_ch.elem_a),
    .zero  (cfg.zero_a),
    .mult  (cfg.mult_a),
    .shift (cfg.shift_a),
    .t     (ta)
  );

  qadd_rescale u_rescale_b (
    .clk   (clk),
    .en    (en),
    .elem  (in_ch.elem_b),
    .zero  (cfg.zero_b),
    .mult  (cfg.mult_b),
    .shift (cfg.shift_b),
    .t     (tb)
  );

  qadd_sum u_sum (
    .clk      (clk),
    .en       (en),
    .ta       (ta),
    .tb       (tb),
    .zero_out (cfg.zero_out),
    .sum_q    (out_ch.sum_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) lst <= {lst[STAGES-2:0], in_ch.last_in};
  end

  assign out_ch.valid    = vld[STAGES-1];
  assign out_ch.last_out = lst[STAGES-1];

endmodule

@@ design/qadd_cfg.sv @@
// ---------------------------------------------------------------------------
// qadd_cfg: configuration registers
// Holds multipliers, shift exponents and zero points; writes to unknown
// indexes are dropped.
// ---------------------------------------------------------------------------
module qadd_cfg import qadd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qadd_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  // no transfer while the registers are held in reset
  assign cfg_ch.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mult_a   <= MULT_RST;
      cfg.shift_a  <= SHIFT_RST;
      cfg.mult_b   <= MULT_RST;
      cfg.shift_b  <= SHIFT_RST;
      cfg.zero_a   <= ZERO_RST;
      cfg.zero_b   <= ZERO_RST;
      cfg.zero_out <= ZERO_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MULT_A:   cfg.mult_a   <= cfg_ch.data[30:0];
        REG_SHIFT_A:  cfg.shift_a  <= cfg_ch.data[5:0];
        REG_MULT_B:   cfg.mult_b   <= cfg_ch.data[30:0];
        REG_SHIFT_B:  cfg.shift_b  <= cfg_ch.data[5:0];
        REG_ZERO_A:   cfg.zero_a   <= cfg_ch.data[7:0];
        REG_ZERO_B:   cfg.zero_b   <= cfg_ch.data[7:0];
        REG_ZERO_OUT: cfg.zero_out <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/qadd_rescale.sv @@
// ---------------------------------------------------------------------------
// qadd_rescale: per-operand rescale pipeline
// Three stages: zero-point subtract and pre-shift, high half of the
// multiplier product, rounding arithmetic right shift.
// ---------------------------------------------------------------------------
module qadd_rescale import qadd_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  q8_t    elem,
  input  q8_t    zero,
  input  mult_t  mult,
  input  shift_t shift,
  output word_t  t
);

  logic signed [8:0]  diff;
  logic [4:0]         amt;
  word_t              dsh_next;
  post_t              post_next;
  word_t              dsh;
  post_t              post1;
  logic signed [63:0] prod;
  word_t              hi;
  post_t              post2;
  logic signed [32:0] rnd;
  logic signed [32:0] h33;
  logic signed [32:0] q33;
  word_t              t_next;

  // stage 1
  always_comb begin
    diff = {elem[7], elem} - {zero[7], zero};
    amt  = shift[4:0] + 5'd2;
    if (!shift[5]) begin
      dsh_next  = word_t'(32'(diff) << amt);
      post_next = 5'd1;
    end else begin
      dsh_next  = word_t'(diff);
      post_next = ~shift[4:0];
    end
  end

  // stage 2
  assign prod = dsh * $signed({1'b0, mult});

  // stage 3: round half up, then arithmetic shift
  always_comb begin
    rnd = 33'sd1 <<< (post2 - 5'd1);
    h33 = {hi[31], hi} + rnd;
    q33 = h33 >>> post2;
    if (post2 == 5'd0) t_next = hi;
    else               t_next = q33[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsh   <= dsh_next;
      post1 <= post_next;
      hi    <= prod[63:32];
      post2 <= post1;
      t     <= t_next;
    end
  end

endmodule

@@ design/qadd_sum.sv @@
// ---------------------------------------------------------------------------
// qadd_sum: sum and saturate
// Adds both rescaled terms and the output zero point with 32-bit wrap and
// clamps the result to int8.
// ---------------------------------------------------------------------------
module qadd_sum import qadd_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t ta,
  input  word_t tb,
  input  q8_t   zero_out,
  output q8_t   sum_q
);

  word_t s;
  q8_t   sat;

  always_comb begin
    s = ta + tb + word_t'(zero_out);
    if (s > 32'sd127)       sat = 8'sd127;
    else if (s < -32'sd128) sat = -8'sd128;
    else                    sat = s[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) sum_q <= sat;
  end

endmodule
